@@ design/ffds_pkg.sv @@
// shared types, constants and the direction compare for the flow field direction stencil
package ffds_pkg;

   localparam int MAX_WIDTH      = 32;
   localparam int DIST_BITS      = 16;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = 16;
   localparam int CFG_WIDTH_BITS = 6;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;
   localparam int DIR_BITS       = 4;
   localparam int RSP_FIELD_BITS = COL_BITS + ROW_BITS + DIR_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_TDATA_BITS = ((DIST_BITS + 7) / 8) * 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_GRID_WIDTH  = 4'd0,
      REG_GRID_HEIGHT = 4'd1
   } reg_index_type;

   typedef enum logic [DIR_BITS-1:0] {
      DIR_END       = 4'd0,
      DIR_RIGHT     = 4'd1,
      DIR_LEFT      = 4'd2,
      DIR_UP        = 4'd3,
      DIR_DOWN      = 4'd4,
      DIR_UPRIGHT   = 4'd5,
      DIR_UPLEFT    = 4'd6,
      DIR_DOWNRIGHT = 4'd7,
      DIR_DOWNLEFT  = 4'd8,
      DIR_STUCK     = 4'd9
   } dir_type;

   // one column of the 3x3 window: row above, center row, row below
   typedef struct packed {
      logic [DIST_BITS-1:0] up;
      logic [DIST_BITS-1:0] mid;
      logic [DIST_BITS-1:0] dn;
   } col_type;

   // line memory word: newer row in hi, older row in lo
   typedef struct packed {
      logic [DIST_BITS-1:0] hi;
      logic [DIST_BITS-1:0] lo;
   } pair_type;

   typedef struct packed {
      logic                en;
      logic [COL_BITS-1:0] addr;
      pair_type            data;
   } mem_wr_type;

   // one column step through the window stage, from the stream or from the flush sweep
   typedef struct packed {
      logic                 flush;
      logic [COL_BITS-1:0]  pos;
      logic                 end_col;
      logic [ROW_BITS-1:0]  out_y;
      logic                 emit_ok;
      logic                 up_ok;
      logic                 dn_ok;
      logic                 mark_last;
      logic [DIST_BITS-1:0] distance;
   } item_type;

   function automatic dir_type dir_of(input col_type lft, input col_type ctr,
                                      input col_type rgt, input logic l_ok,
                                      input logic r_ok, input logic u_ok,
                                      input logic d_ok);
      logic [DIST_BITS-1:0] best;
      dir_type              code;
      best = ctr.mid;
      code = DIR_STUCK;
      if (l_ok && (lft.mid < best)) begin
         best = lft.mid;
         code = DIR_LEFT;
      end
      if (r_ok && (rgt.mid < best)) begin
         best = rgt.mid;
         code = DIR_RIGHT;
      end
      if (u_ok && (ctr.up < best)) begin
         best = ctr.up;
         code = DIR_UP;
      end
      if (d_ok && (ctr.dn < best)) begin
         best = ctr.dn;
         code = DIR_DOWN;
      end
      if (l_ok && d_ok && (lft.dn < best)) begin
         best = lft.dn;
         code = DIR_DOWNLEFT;
      end
      if (r_ok && u_ok && (rgt.up < best)) begin
         best = rgt.up;
         code = DIR_UPRIGHT;
      end
      if (l_ok && u_ok && (lft.up < best)) begin
         best = lft.up;
         code = DIR_UPLEFT;
      end
      if (r_ok && d_ok && (rgt.dn < best)) begin
         best = rgt.dn;
         code = DIR_DOWNRIGHT;
      end
      if (best == '0) begin
         code = DIR_END;
      end
      return code;
   endfunction

endpackage

@@ design/flow_field_direction_stencil.sv @@
// top level: raster position, frame flush sweep, configuration registers
// Takes one distance per cycle in raster order and gives each cell a direction code toward
// its smallest neighbour, or an end or stuck code. A cell's result is registered in the window
// stage and then in the result register after the input that completes its neighbourhood; an
// item that ends a row gives two results (one on a one-column grid) and holds the window stage
// for both, and the last item of a frame adds a flush sweep that reads the line memory one
// column per cycle, taking no input. Otherwise one item is taken every cycle. Both hold while
// results are taken, and input waits on register writes; the single result register and the
// one read port of the line memory set these limits. Writing either register restarts the frame.
module flow_field_direction_stencil (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ffds_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // dist_req
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [ffds_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,  // cell_x, cell_y, direction
   output logic                                  rsp_tlast,  // last_of_run
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ffds_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ffds_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import ffds_pkg::*;

   logic [COL_BITS-1:0]  col_pos_ff,  col_pos_in;
   logic [ROW_BITS-1:0]  row_pos_ff,  row_pos_in;
   logic [COL_BITS-1:0]  w_last_ff,   w_last_in;
   logic [ROW_BITS-1:0]  h_last_ff,   h_last_in;
   logic                 flush_ff,    flush_in;
   logic [COL_BITS-1:0]  flush_x_ff,  flush_x_in;
   logic [ROW_BITS-1:0]  flush_y_ff,  flush_y_in;
   logic                 flush_dn_ff, flush_dn_in;

   logic [COL_BITS-1:0]       c_clamp;
   logic                      end_col;
   logic                      frame_end;
   logic                      accept;
   logic                      flush_issue;
   logic                      load;
   logic                      advance;
   logic [COL_BITS-1:0]       rd_addr;
   logic [CFG_WIDTH_BITS-1:0] wv;
   item_type                  item;
   pair_type                  rd_pair;
   mem_wr_type                mem_wr;

   always_comb begin
      c_clamp     = (col_pos_ff > w_last_ff) ? w_last_ff : col_pos_ff;
      end_col     = c_clamp == w_last_ff;
      frame_end   = end_col && (row_pos_ff >= h_last_ff);
      req_tready  = advance && !flush_ff && !csr_valid;
      csr_ready   = 1'b1;
      accept      = req_tvalid && req_tready;
      flush_issue = flush_ff && advance;
      load        = accept || flush_issue;
      rd_addr     = flush_ff ? flush_x_ff : c_clamp;
      wv          = csr_data[CFG_WIDTH_BITS-1:0];

      if (flush_ff) begin
         item.flush     = 1'b1;
         item.pos       = flush_x_ff;
         item.end_col   = flush_x_ff == w_last_ff;
         item.out_y     = flush_y_ff;
         item.emit_ok   = 1'b1;
         item.up_ok     = 1'b0;
         item.dn_ok     = flush_dn_ff;
         item.mark_last = flush_x_ff == w_last_ff;
         item.distance  = '0;
      end else begin
         item.flush     = 1'b0;
         item.pos       = c_clamp;
         item.end_col   = end_col;
         item.out_y     = row_pos_ff - ROW_BITS'(1);
         item.emit_ok   = row_pos_ff != '0;
         item.up_ok     = 1'b1;
         item.dn_ok     = row_pos_ff > ROW_BITS'(1);
         item.mark_last = !frame_end;
         item.distance  = req_tdata[DIST_BITS-1:0];
      end

      col_pos_in  = col_pos_ff;
      row_pos_in  = row_pos_ff;
      w_last_in   = w_last_ff;
      h_last_in   = h_last_ff;
      flush_in    = flush_ff;
      flush_x_in  = flush_x_ff;
      flush_y_in  = flush_y_ff;
      flush_dn_in = flush_dn_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_GRID_WIDTH: begin
               col_pos_in = '0;
               row_pos_in = '0;
               if (wv == '0) begin
                  w_last_in = '0;
               end else if (wv > CFG_WIDTH_BITS'(MAX_WIDTH)) begin
                  w_last_in = COL_BITS'(MAX_WIDTH - 1);
               end else begin
                  w_last_in = COL_BITS'(wv - CFG_WIDTH_BITS'(1));
               end
            end
            REG_GRID_HEIGHT: begin
               col_pos_in = '0;
               row_pos_in = '0;
               h_last_in  = (csr_data == '0) ? '0 : ROW_BITS'(csr_data - CSR_DATA_BITS'(1));
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (frame_end) begin
            col_pos_in  = '0;
            row_pos_in  = '0;
            flush_in    = 1'b1;
            flush_x_in  = '0;
            flush_y_in  = row_pos_ff;
            flush_dn_in = row_pos_ff != '0;
         end else if (end_col) begin
            col_pos_in = '0;
            row_pos_in = row_pos_ff + ROW_BITS'(1);
         end else begin
            col_pos_in = c_clamp + COL_BITS'(1);
         end
      end else if (flush_issue) begin
         flush_x_in = flush_x_ff + COL_BITS'(1);
         if (flush_x_ff == w_last_ff) begin
            flush_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         w_last_ff   <= COL_BITS'(MAX_WIDTH - 1);
         h_last_ff   <= ROW_BITS'(31);
         flush_ff    <= 1'b0;
         flush_x_ff  <= '0;
         flush_y_ff  <= '0;
         flush_dn_ff <= 1'b0;
      end else begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         w_last_ff   <= w_last_in;
         h_last_ff   <= h_last_in;
         flush_ff    <= flush_in;
         flush_x_ff  <= flush_x_in;
         flush_y_ff  <= flush_y_in;
         flush_dn_ff <= flush_dn_in;
      end
   end

   ffds_line_mem u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (load),
      .rd_addr (rd_addr),
      .mem_wr  (mem_wr),
      .rd_pair (rd_pair)
   );

   ffds_window u_window (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .item       (item),
      .rd_pair    (rd_pair),
      .advance    (advance),
      .mem_wr     (mem_wr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ design/ffds_line_mem.sv @@
// line buffer memory holding the two previous rows per column, with write-to-read forwarding
module ffds_line_mem (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [ffds_pkg::COL_BITS-1:0] rd_addr,
   input  ffds_pkg::mem_wr_type     mem_wr,
   output ffds_pkg::pair_type       rd_pair
);
   import ffds_pkg::*;

   pair_type mem [MAX_WIDTH];
   pair_type rd_ff;
   pair_type fwd_data_ff;
   logic     fwd_sel_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.addr] <= mem_wr.data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         fwd_data_ff <= mem_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_sel_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_sel_ff <= mem_wr.en && (mem_wr.addr == rd_addr);
      end
   end

   assign rd_pair = fwd_sel_ff ? fwd_data_ff : rd_ff;

endmodule

@@ design/ffds_window.sv @@
// 3x3 window stage: column shift, direction compare and result register
module ffds_window (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  ffds_pkg::item_type       item,
   input  ffds_pkg::pair_type       rd_pair,
   output logic                     advance,
   output ffds_pkg::mem_wr_type     mem_wr,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [ffds_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);
   import ffds_pkg::*;

   item_type             s1_ff;
   logic                 s1_valid_ff;
   logic                 phase_ff;
   col_type              win1_ff;
   col_type              win2_ff;
   logic                 rsp_valid_ff;
   logic [COL_BITS-1:0]  rsp_x_ff;
   logic [ROW_BITS-1:0]  rsp_y_ff;
   dir_type              rsp_dir_ff;
   logic                 rsp_last_ff;

   col_type              new_col;
   col_type              c_left;
   col_type              c_ctr;
   col_type              c_right;
   logic                 l_ok;
   logic                 r_ok;
   logic [COL_BITS-1:0]  res_x;
   logic                 need_a;
   logic                 need_b;
   logic                 is_b;
   logic                 has_res;
   logic                 final_step;
   logic                 out_free;
   logic                 push;
   logic                 retire;
   dir_type              dir;

   always_comb begin
      new_col.up  = s1_ff.distance;
      new_col.mid = rd_pair.hi;
      new_col.dn  = rd_pair.lo;
      need_a      = s1_ff.emit_ok && (s1_ff.pos != '0);
      need_b      = s1_ff.emit_ok && s1_ff.end_col;
      is_b        = phase_ff || !need_a;
      has_res     = s1_valid_ff && (need_a || need_b);
      final_step  = is_b || !need_b;
      out_free    = !rsp_valid_ff || rsp_tready;
      push        = has_res && out_free;
      retire      = s1_valid_ff && (!has_res || (push && final_step));
      advance     = !s1_valid_ff || retire;
      // second result of a row end: center is the new column, nothing to its right
      if (is_b) begin
         c_left  = win1_ff;
         c_ctr   = new_col;
         c_right = new_col;
         l_ok    = s1_ff.pos != '0;
         r_ok    = 1'b0;
         res_x   = s1_ff.pos;
      end else begin
         c_left  = win2_ff;
         c_ctr   = win1_ff;
         c_right = new_col;
         l_ok    = s1_ff.pos > COL_BITS'(1);
         r_ok    = 1'b1;
         res_x   = s1_ff.pos - COL_BITS'(1);
      end
      dir = dir_of(c_left, c_ctr, c_right, l_ok, r_ok, s1_ff.up_ok, s1_ff.dn_ok);
      mem_wr.en      = retire && !s1_ff.flush;
      mem_wr.addr    = s1_ff.pos;
      mem_wr.data.hi = s1_ff.distance;
      mem_wr.data.lo = rd_pair.hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_valid_ff <= load;
         end
         if (retire) begin
            phase_ff <= 1'b0;
         end else if (push) begin
            phase_ff <= 1'b1;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load) begin
         s1_ff <= item;
      end
      if (retire) begin
         win2_ff <= win1_ff;
         win1_ff <= new_col;
      end
      if (push) begin
         rsp_x_ff    <= res_x;
         rsp_y_ff    <= s1_ff.out_y;
         rsp_dir_ff  <= dir;
         rsp_last_ff <= final_step && s1_ff.mark_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - RSP_FIELD_BITS){1'b0}},
                        rsp_dir_ff, rsp_y_ff, rsp_x_ff};

endmodule
